/* rtl/sequence_reorder_buffer_assert.svh */
// Assertion macros for the reorder buffer top level.
`ifndef SEQUENCE_REORDER_BUFFER_ASSERT_SVH
`define SEQUENCE_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srb_pkg.sv */
// Shared types and constants for the sequence reorder buffer.
package srb_pkg;

  localparam int WindowDefault       = 16;
  localparam int PayloadBytesDefault = 8;
  localparam int MaxFlush            = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    INS_STORED = 2'd0,
    INS_DUP    = 2'd1,
    INS_OLD    = 2'd2,
    INS_JUMP   = 2'd3
  } ins_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHOW,
    S_FL_READ,
    S_FL_EVAL,
    S_FL_SHOW
  } state_t;

  typedef struct packed {
    logic ins_exec;    // run insert on the accepted item
    logic fl_start;    // capture capacity, clear flush totals
    logic load_pkt;    // load head packet into output, shift window
    logic load_empty;  // load empty flush result
    logic mark;        // settle last flag of held packet result
  } cmd_t;

  typedef struct packed {
    logic go;          // head packet may be emitted
    logic first;       // nothing emitted yet in this flush
    logic last;        // held result is the final one
  } sts_t;

endpackage

/* rtl/sequence_reorder_buffer.sv */
// Top level of the sequence reorder buffer: controller plus window datapath.
// Insert: the result is offered the cycle after accept; no new item is taken until it is accepted.
// Flush: each result passes S_FL_READ (slot memory read) and S_FL_EVAL before it is
//   offered in S_FL_SHOW; each further packet is loaded on the previous accept.
// Reset (synchronous, rst_n low): window empty, expected number 0.
`include "sequence_reorder_buffer_assert.svh"
module sequence_reorder_buffer
  import srb_pkg::*;
#(
  parameter int WINDOW        = WindowDefault,
  parameter int PAYLOAD_BYTES = PayloadBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_seq_number,
  input  logic [63:0] in_payload,
  input  logic [3:0]  in_payload_len,
  input  logic [15:0] in_byte_capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_packet_valid,
  output logic [15:0] out_packet_seq,
  output logic [63:0] out_packet_data,
  output logic [3:0]  out_packet_len,
  output logic [15:0] out_bytes_so_far,
  output logic [4:0]  out_packets_so_far,
  output logic [15:0] out_next_expected,
  output logic        out_last
);

  cmd_t cmd;
  sts_t sts;

  srb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srb_datapath #(
    .WINDOW        (WINDOW),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_seq_number      (in_seq_number),
    .in_payload         (in_payload),
    .in_payload_len     (in_payload_len),
    .in_byte_capacity   (in_byte_capacity),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_status),
    .out_packet_valid   (out_packet_valid),
    .out_packet_seq     (out_packet_seq),
    .out_packet_data    (out_packet_data),
    .out_packet_len     (out_packet_len),
    .out_bytes_so_far   (out_bytes_so_far),
    .out_packets_so_far (out_packets_so_far),
    .out_next_expected  (out_next_expected),
    .out_last           (out_last)
  );

  `SRB_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while result pending")
  `SRB_ASSERT_NOW(a_empty_is_last, out_valid && !out_packet_valid, out_last,
                  "result without packet is not last")
  `SRB_ASSERT_NOW(a_status_is_last, out_valid && (out_status != INS_STORED), out_last,
                  "insert status on a non-final result")
  `SRB_ASSERT_NEXT(a_flush_continues, out_valid && out_ready && !out_last, !in_ready,
                   "flush ended without a last result")

endmodule

/* rtl/srb_ctrl.sv */
// Controller state machine for the sequence reorder buffer.
module srb_ctrl
  import srb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == KIND_FLUSH) ? S_FL_READ : S_INS_SHOW;
        end
      end
      S_INS_SHOW: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      S_FL_READ: state_nxt = S_FL_EVAL;
      S_FL_EVAL: begin
        if (sts.first && sts.go) state_nxt = S_FL_READ;
        else                     state_nxt = S_FL_SHOW;
      end
      S_FL_SHOW: begin
        if (out_ready) state_nxt = sts.last ? S_IDLE : S_FL_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ins_exec = (in_kind == KIND_INSERT);
          cmd.fl_start = (in_kind == KIND_FLUSH);
        end
      end
      S_INS_SHOW: out_valid = 1'b1;
      S_FL_READ: ;
      S_FL_EVAL: begin
        if (sts.first) begin
          cmd.load_pkt   = sts.go;
          cmd.load_empty = !sts.go;
        end else begin
          cmd.mark = 1'b1;
        end
      end
      S_FL_SHOW: begin
        out_valid = 1'b1;
        // next packet was already judged to go; take it on the accept
        cmd.load_pkt = out_ready && !sts.last;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/srb_datapath.sv */
// Window storage, insert logic and result registers of the reorder buffer.
module srb_datapath
  import srb_pkg::*;
#(
  parameter int WINDOW        = WindowDefault,
  parameter int PAYLOAD_BYTES = PayloadBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] in_seq_number,
  input  logic [63:0] in_payload,
  input  logic [3:0]  in_payload_len,
  input  logic [15:0] in_byte_capacity,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [1:0]  out_status,
  output logic        out_packet_valid,
  output logic [15:0] out_packet_seq,
  output logic [63:0] out_packet_data,
  output logic [3:0]  out_packet_len,
  output logic [15:0] out_bytes_so_far,
  output logic [4:0]  out_packets_so_far,
  output logic [15:0] out_next_expected,
  output logic        out_last
);

  localparam int IW    = $clog2(WINDOW);
  localparam int PW    = PAYLOAD_BYTES * 8;
  localparam int Limit = (WINDOW < MaxFlush) ? WINDOW : MaxFlush;

  // slot store: length over payload, indexed by physical slot
  logic [PW+3:0] mem [WINDOW];
  logic [PW+3:0] rd_data_r;

  logic [WINDOW-1:0] valid_r, valid_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [15:0]       expected_r, expected_nxt;
  logic [15:0]       cap_r;
  logic [15:0]       total_r;
  logic [4:0]        count_r;

  logic [15:0]   off;
  logic [IW:0]   idx_sum;
  logic [IW-1:0] wr_idx;
  logic [3:0]    len_sat;
  logic [63:0]   data_mask;
  logic          wr_en;
  ins_status_t   ins_st;

  logic [3:0]  rd_len;
  logic [16:0] total_sum;

  assign rd_len    = rd_data_r[PW+3:PW];
  assign total_sum = {1'b0, total_r} + 17'(rd_len);

  assign sts.go    = valid_r[head_r] && (count_r < 5'(Limit))
                     && (total_sum <= {1'b0, cap_r});
  assign sts.first = (count_r == 5'd0);
  assign sts.last  = out_last;

  assign off = in_seq_number - expected_r;

  always_comb begin
    len_sat = (in_payload_len > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : in_payload_len;
    for (int b = 0; b < 8; b++) begin
      data_mask[b*8 +: 8] = (4'(b) < len_sat) ? in_payload[b*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    expected_nxt = expected_r;
    head_nxt     = head_r;
    wr_en        = 1'b0;
    ins_st       = INS_STORED;
    idx_sum      = {1'b0, head_r} + (IW+1)'(off[IW-1:0]);
    if (idx_sum >= (IW+1)'(WINDOW)) idx_sum = idx_sum - (IW+1)'(WINDOW);
    wr_idx = idx_sum[IW-1:0];

    if (cmd.ins_exec) begin
      if (off[15]) begin
        ins_st = INS_OLD;
      end else if (off >= 16'(WINDOW)) begin
        // far ahead: drop the window and restart it at this number
        valid_nxt         = '0;
        valid_nxt[head_r] = 1'b1;
        expected_nxt      = in_seq_number;
        wr_idx            = head_r;
        wr_en             = 1'b1;
        ins_st            = INS_JUMP;
      end else if (valid_r[wr_idx]) begin
        ins_st = INS_DUP;
      end else begin
        valid_nxt[wr_idx] = 1'b1;
        wr_en             = 1'b1;
      end
    end

    if (cmd.load_pkt) begin
      valid_nxt[head_r] = 1'b0;
      expected_nxt      = expected_r + 16'd1;
      head_nxt          = (head_r == IW'(WINDOW - 1)) ? '0 : head_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= {len_sat, data_mask[PW-1:0]};
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      head_r     <= '0;
      expected_r <= '0;
      total_r    <= '0;
      count_r    <= '0;
      out_last   <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      head_r     <= head_nxt;
      expected_r <= expected_nxt;
      if (cmd.fl_start) begin
        total_r <= '0;
        count_r <= '0;
      end else if (cmd.load_pkt) begin
        total_r <= total_sum[15:0];
        count_r <= count_r + 5'd1;
      end
      if (cmd.ins_exec || cmd.load_empty) out_last <= 1'b1;
      else if (cmd.load_pkt)              out_last <= 1'b0;
      else if (cmd.mark)                  out_last <= !sts.go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fl_start) cap_r <= in_byte_capacity;
    if (cmd.ins_exec || cmd.load_empty) begin
      out_status         <= cmd.ins_exec ? ins_st : INS_STORED;
      out_packet_valid   <= 1'b0;
      out_packet_seq     <= '0;
      out_packet_data    <= '0;
      out_packet_len     <= '0;
      out_bytes_so_far   <= '0;
      out_packets_so_far <= '0;
      out_next_expected  <= expected_nxt;
    end else if (cmd.load_pkt) begin
      out_status         <= INS_STORED;
      out_packet_valid   <= 1'b1;
      out_packet_seq     <= expected_r;
      out_packet_data    <= 64'(rd_data_r[PW-1:0]);
      out_packet_len     <= rd_len;
      out_bytes_so_far   <= total_sum[15:0];
      out_packets_so_far <= count_r + 5'd1;
      out_next_expected  <= expected_nxt;
    end
  end

endmodule
